[rtl/psa_pkg.sv]
// Shared types, constants and helpers for the saturation adjust pipeline.
package psa_pkg;

   localparam int PIX_W      = 8;
   localparam int GAIN_W     = 12;
   localparam int CH_NUM     = 3;
   localparam int CH_BLUE    = 0;
   localparam int CH_GREEN   = 1;
   localparam int CH_RED     = 2;

   // unpremultiplied value c*255*256/a, up to 24 bits when color exceeds alpha
   localparam int QUO_W      = 24;
   localparam int DIV_STAGES = 4;
   localparam int DIV_BITS   = QUO_W / DIV_STAGES;

   localparam int WEIGHT_W   = 16;
   localparam int PROD_W     = 40;   // weight * quotient, and the gray sum
   localparam int DIFF_W     = 42;   // u*65536 - gray, signed
   localparam int MIX_W      = 54;   // gain * diff, signed
   localparam int BLEND_W    = 55;   // gray*256 + gain*diff, signed
   localparam int FRAC_W     = 32;

   localparam logic signed [GAIN_W-1:0] GAIN_ONE = 12'sd256;

   localparam logic [BLEND_W-1:0] ROUND_HALF =
      {{(BLEND_W-FRAC_W){1'b0}}, 1'b1, {(FRAC_W-1){1'b0}}};

   // BT.601 luma weights in Q0.16, indexed by channel (blue, green, red)
   localparam logic [WEIGHT_W-1:0] LUMA_WEIGHT [CH_NUM] = '{
      16'd7471, 16'd38470, 16'd19595
   };

   typedef logic [CH_NUM-1:0][PIX_W-1:0] pix_vec_type;
   typedef logic [CH_NUM-1:0][QUO_W-1:0] quo_vec_type;

   typedef struct packed {
      logic [PIX_W-1:0]         blue;
      logic [PIX_W-1:0]         green;
      logic [PIX_W-1:0]         red;
      logic [PIX_W-1:0]         alpha;
      logic signed [GAIN_W-1:0] gain;
      logic                     bypass;
   } side_type;

   function automatic pix_vec_type side_colors(side_type side);
      pix_vec_type colors;
      colors[CH_BLUE]  = side.blue;
      colors[CH_GREEN] = side.green;
      colors[CH_RED]   = side.red;
      return colors;
   endfunction

endpackage

[rtl/psa_divider.sv]
// Pipelined restoring divider: c*65280/alpha for three channels.
module psa_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  psa_pkg::side_type     in_side,
   output logic                  out_valid,
   input  logic                  out_ready,
   output psa_pkg::side_type     out_side,
   output psa_pkg::quo_vec_type  out_quo
);
   import psa_pkg::*;

   localparam int LAST = DIV_STAGES;

   typedef struct packed {
      logic [QUO_W-1:0] num;
      logic [PIX_W-1:0] rem;
      logic [QUO_W-1:0] quo;
   } div_type;

   logic [LAST:0]   valid_ff;
   logic [LAST:0]   valid_in;
   logic [LAST+1:0] ready;
   side_type        side_ff [LAST+1];
   side_type        side_in [LAST+1];
   div_type         div_ff  [LAST+1][CH_NUM];
   div_type         div_in  [LAST+1][CH_NUM];

   always_comb begin
      ready[LAST+1] = out_ready;
      for (int s = LAST; s >= 0; s--) begin
         ready[s] = !valid_ff[s] || ready[s+1];
      end
   end

   always_comb begin
      pix_vec_type      colors;
      div_type          st;
      logic [PIX_W:0]   rem9;
      logic [PIX_W-1:0] divisor;
      colors      = side_colors(in_side);
      valid_in[0] = in_valid;
      side_in[0]  = in_side;
      for (int ch = 0; ch < CH_NUM; ch++) begin
         // c*255*256 = c*65536 - c*256
         div_in[0][ch].num = QUO_W'({colors[ch], 16'h0000}) - QUO_W'({colors[ch], 8'h00});
         div_in[0][ch].rem = '0;
         div_in[0][ch].quo = '0;
      end
      for (int s = 1; s <= LAST; s++) begin
         valid_in[s] = valid_ff[s-1];
         side_in[s]  = side_ff[s-1];
         divisor     = side_ff[s-1].alpha;
         for (int ch = 0; ch < CH_NUM; ch++) begin
            st = div_ff[s-1][ch];
            for (int b = 0; b < DIV_BITS; b++) begin
               rem9   = {st.rem, st.num[QUO_W-1]};
               st.num = {st.num[QUO_W-2:0], 1'b0};
               if (rem9 >= {1'b0, divisor}) begin
                  st.rem = PIX_W'(rem9 - {1'b0, divisor});
                  st.quo = {st.quo[QUO_W-2:0], 1'b1};
               end else begin
                  st.rem = rem9[PIX_W-1:0];
                  st.quo = {st.quo[QUO_W-2:0], 1'b0};
               end
            end
            div_in[s][ch] = st;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int s = 0; s <= LAST; s++) begin
            if (ready[s]) begin
               valid_ff[s] <= valid_in[s];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s <= LAST; s++) begin
         if (ready[s]) begin
            side_ff[s] <= side_in[s];
            for (int ch = 0; ch < CH_NUM; ch++) begin
               div_ff[s][ch] <= div_in[s][ch];
            end
         end
      end
   end

   always_comb begin
      for (int ch = 0; ch < CH_NUM; ch++) begin
         out_quo[ch] = div_ff[LAST][ch].quo;
      end
   end

   assign in_ready  = ready[0];
   assign out_valid = valid_ff[LAST];
   assign out_side  = side_ff[LAST];

endmodule

[rtl/psa_blend.sv]
// Gray, gain blend, rounding and clamp: four register stages.
module psa_blend (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  psa_pkg::side_type     in_side,
   input  psa_pkg::quo_vec_type  in_quo,
   output logic                  out_valid,
   input  logic                  out_ready,
   output psa_pkg::side_type     out_side,
   output psa_pkg::pix_vec_type  out_level
);
   import psa_pkg::*;

   localparam int NSTG = 4;

   logic [NSTG-1:0] valid_ff;
   logic [NSTG-1:0] valid_in;
   logic [NSTG:0]   ready;

   // stage 0: weighted products
   side_type                   side0_ff;
   quo_vec_type                quo0_ff;
   logic [PROD_W-1:0]          prod0_ff [CH_NUM];
   logic [PROD_W-1:0]          prod0_in [CH_NUM];
   // stage 1: gray and differences
   side_type                   side1_ff;
   logic [PROD_W-1:0]          gray1_ff;
   logic [PROD_W-1:0]          gray1_in;
   logic signed [DIFF_W-1:0]   diff1_ff [CH_NUM];
   logic signed [DIFF_W-1:0]   diff1_in [CH_NUM];
   // stage 2: gain products
   side_type                   side2_ff;
   logic [PROD_W-1:0]          gray2_ff;
   logic signed [MIX_W-1:0]    mix2_ff [CH_NUM];
   logic signed [MIX_W-1:0]    mix2_in [CH_NUM];
   // stage 3: rounded and clamped level
   side_type                   side3_ff;
   pix_vec_type                level3_ff;
   pix_vec_type                level3_in;

   always_comb begin
      ready[NSTG] = out_ready;
      for (int s = NSTG - 1; s >= 0; s--) begin
         ready[s] = !valid_ff[s] || ready[s+1];
      end
      valid_in[0] = in_valid;
      for (int s = 1; s < NSTG; s++) begin
         valid_in[s] = valid_ff[s-1];
      end
   end

   always_comb begin
      logic signed [BLEND_W-1:0] mixed;
      logic [BLEND_W-1:0]        rounded;
      for (int ch = 0; ch < CH_NUM; ch++) begin
         prod0_in[ch] = PROD_W'(LUMA_WEIGHT[ch]) * PROD_W'(in_quo[ch]);
      end
      gray1_in = prod0_ff[CH_BLUE] + prod0_ff[CH_GREEN] + prod0_ff[CH_RED];
      for (int ch = 0; ch < CH_NUM; ch++) begin
         diff1_in[ch] = $signed({2'b00, quo0_ff[ch], 16'h0000})
                      - $signed({2'b00, gray1_in});
         mix2_in[ch]  = MIX_W'($signed(side1_ff.gain)) * MIX_W'(diff1_ff[ch]);
      end
      for (int ch = 0; ch < CH_NUM; ch++) begin
         mixed   = $signed({7'b0, gray2_ff, 8'h00}) + BLEND_W'(mix2_ff[ch]);
         rounded = $unsigned(mixed) + ROUND_HALF;
         if (mixed[BLEND_W-1]) begin
            level3_in[ch] = '0;
         end else if (|rounded[BLEND_W-1:FRAC_W+PIX_W]) begin
            level3_in[ch] = '1;
         end else begin
            level3_in[ch] = rounded[FRAC_W+PIX_W-1:FRAC_W];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int s = 0; s < NSTG; s++) begin
            if (ready[s]) begin
               valid_ff[s] <= valid_in[s];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready[0]) begin
         side0_ff <= in_side;
         quo0_ff  <= in_quo;
         prod0_ff <= prod0_in;
      end
      if (ready[1]) begin
         side1_ff <= side0_ff;
         gray1_ff <= gray1_in;
         diff1_ff <= diff1_in;
      end
      if (ready[2]) begin
         side2_ff <= side1_ff;
         gray2_ff <= gray1_ff;
         mix2_ff  <= mix2_in;
      end
      if (ready[3]) begin
         side3_ff  <= side2_ff;
         level3_ff <= level3_in;
      end
   end

   assign in_ready  = ready[0];
   assign out_valid = valid_ff[NSTG-1];
   assign out_side  = side3_ff;
   assign out_level = level3_ff;

endmodule

[rtl/premultiplied_saturation_adjust_core.sv]
// Saturation adjust for premultiplied BGRA8 pixels: top level.
//
// Pixels enter on the req_ stream and leave on the rsp_ stream, one result per
// pixel, in order. A pixel is taken on every clock while the pipeline can move,
// so throughput is one pixel per cycle; a result shows on rsp_tvalid after it
// has passed five divider stages, four blend stages and the output register.
// The unpremultiply divider resolves six quotient bits in each stage after its
// input stage; the gain product is the widest multiply and has its own stage.
// When rsp_tready is low, stages fill up behind the output register and
// req_tready drops only once every stage holds a pixel; no pixel is lost.
// csr_wr_en writes the signed Q4.8 gain; each pixel takes the gain present at
// its input transfer. Write it only while the pipeline is empty.
// Reset empties the pipeline and sets the gain to 1.0 (pass-through).
// Zero alpha or unit gain returns the pixel unchanged.
module premultiplied_saturation_adjust_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,    // in_blue, in_green, in_red, in_alpha
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,    // out_blue, out_green, out_red, out_alpha
   input  logic        csr_wr_en,
   input  logic [11:0] csr_wr_data   // saturation_gain
);
   import psa_pkg::*;

   logic signed [GAIN_W-1:0] gain_ff;
   side_type                 req_side;

   logic        div_valid;
   logic        div_ready;
   side_type    div_side;
   quo_vec_type div_quo;

   logic        blend_valid;
   logic        blend_ready;
   side_type    blend_side;
   pix_vec_type blend_level;

   logic        rsp_valid_ff;
   pix_vec_type rsp_pix_ff;
   pix_vec_type rsp_pix_in;
   logic [PIX_W-1:0] rsp_alpha_ff;
   logic        rsp_bypass_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= GAIN_ONE;
      end else if (csr_wr_en) begin
         gain_ff <= $signed(csr_wr_data);
      end
   end

   always_comb begin
      req_side.blue   = req_tdata[7:0];
      req_side.green  = req_tdata[15:8];
      req_side.red    = req_tdata[23:16];
      req_side.alpha  = req_tdata[31:24];
      req_side.gain   = gain_ff;
      req_side.bypass = (req_tdata[31:24] == '0) || (gain_ff == GAIN_ONE);
   end

   psa_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_side   (req_side),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_side  (div_side),
      .out_quo   (div_quo)
   );

   psa_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .in_ready  (div_ready),
      .in_side   (div_side),
      .in_quo    (div_quo),
      .out_valid (blend_valid),
      .out_ready (blend_ready),
      .out_side  (blend_side),
      .out_level (blend_level)
   );

   assign blend_ready = !rsp_valid_ff || rsp_tready;

   // re-premultiply: floor(v*a/255) = (x + (x >> 8) + 1) >> 8 for x <= 65025
   always_comb begin
      pix_vec_type        colors;
      logic [2*PIX_W-1:0] scaled;
      logic [2*PIX_W:0]   folded;
      colors = side_colors(blend_side);
      for (int ch = 0; ch < CH_NUM; ch++) begin
         scaled = (2*PIX_W)'(blend_level[ch]) * (2*PIX_W)'(blend_side.alpha);
         folded = (2*PIX_W+1)'(scaled) + (2*PIX_W+1)'(scaled[2*PIX_W-1:PIX_W])
                + (2*PIX_W+1)'(1);
         if (blend_side.bypass) begin
            rsp_pix_in[ch] = colors[ch];
         end else begin
            rsp_pix_in[ch] = folded[2*PIX_W-1:PIX_W];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (blend_ready) begin
         rsp_valid_ff <= blend_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (blend_ready) begin
         rsp_pix_ff    <= rsp_pix_in;
         rsp_alpha_ff  <= blend_side.alpha;
         rsp_bypass_ff <= blend_side.bypass;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_alpha_ff, rsp_pix_ff};

   // an empty output register must let the whole pipeline move
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled while output register is empty");

   // a re-premultiplied channel never exceeds its alpha
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_bypass_ff |->
         rsp_tdata[7:0] <= rsp_tdata[31:24] && rsp_tdata[15:8] <= rsp_tdata[31:24]
         && rsp_tdata[23:16] <= rsp_tdata[31:24])
      else $error("adjusted channel above alpha");

   assert property (@(posedge clock)
      $past(reset) |-> gain_ff == GAIN_ONE)
      else $error("gain not unity after reset");

endmodule
